[src/tlvf_pkg.sv]
// Package for the TLV stream parser with tag filter.
// Holds the item and result codes, the parser phases and the result record type.
// No dependencies.
package tlvf_pkg;

   // Input item kinds carried on req_tuser.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   // Result kinds carried on rsp_tuser.
   localparam logic [1:0] RK_BYTE  = 2'd0;
   localparam logic [1:0] RK_EMPTY = 2'd1;
   localparam logic [1:0] RK_DONE  = 2'd2;
   localparam logic [1:0] RK_ERROR = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_TAG_SHORT = 2'd0;
   localparam logic [1:0] ERR_TAG_BAD   = 2'd1;
   localparam logic [1:0] ERR_LEN_SHORT = 2'd2;
   localparam logic [1:0] ERR_VAL_SHORT = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_BYTE_ORDER = 1'b0;
   localparam logic CSR_TAG_COUNT  = 1'b1;

   // Parser phases.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_TAG0  = 3'd1;
   localparam logic [2:0] PH_TAG1  = 3'd2;
   localparam logic [2:0] PH_LEN0  = 3'd3;
   localparam logic [2:0] PH_LEN1  = 3'd4;
   localparam logic [2:0] PH_VALUE = 3'd5;

   // Width of the reported parse position.
   localparam int POS_BITS = 20;

   // Depth of the result queue; an item is taken only with room for two results.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   // One result record.
   typedef struct packed {
      logic [1:0]          kind;
      logic [15:0]         tag;
      logic [15:0]         len;
      logic [15:0]         offset;
      logic [7:0]          vbyte;
      logic                vend;
      logic [1:0]          code;
      logic [POS_BITS-1:0] pos;
      logic                last;
   } result_type;

   // Status of the tag scan unit.
   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } scan_status_type;

   // Builds a result record with the last flag clear.
   function automatic result_type make_result(
      input logic [1:0]          kind,
      input logic [15:0]         tag,
      input logic [15:0]         len,
      input logic [15:0]         offset,
      input logic [7:0]          vbyte,
      input logic                vend,
      input logic [1:0]          code,
      input logic [POS_BITS-1:0] pos
   );
      result_type r;
      r.kind   = kind;
      r.tag    = tag;
      r.len    = len;
      r.offset = offset;
      r.vbyte  = vbyte;
      r.vend   = vend;
      r.code   = code;
      r.pos    = pos;
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

[src/tlvf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlvf_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tlvf_tag_scan.sv]
// Allowed-tag table and the sequencer that walks it, one entry per cycle,
// comparing each entry with the tag under test. Depends on tlvf_pkg and tlvf_ram.
module tlvf_tag_scan
   import tlvf_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int LIM_W  = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              start,
   input  logic [15:0]       tag,
   input  logic [LIM_W-1:0]  limit,
   output scan_status_type   status
);

   logic              busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic [LIM_W-1:0]  issue_ff, issue_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [15:0]       tag_ff, tag_in;
   logic [15:0]       rd_data;
   logic              hit_now;
   logic              issue_go;
   logic              done;

   tlvf_ram #(
      .WIDTH  (16),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue_go),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // The entry read last cycle is compared here; a match ends the walk early.
   assign hit_now  = pend_ff && (rd_data == tag_ff);
   assign issue_go = busy_ff && !hit_now && (issue_ff < limit_ff);
   assign done     = busy_ff && (hit_now || (!pend_ff && (issue_ff == limit_ff)));

   // Sequencer next state.
   always_comb begin
      busy_in  = busy_ff;
      pend_in  = issue_go;
      issue_in = issue_ff;
      limit_in = limit_ff;
      tag_in   = tag_ff;
      if (start) begin
         busy_in  = 1'b1;
         pend_in  = 1'b0;
         issue_in = '0;
         limit_in = limit;
         tag_in   = tag;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (issue_go) begin
         issue_in = issue_ff + LIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      limit_ff <= limit_in;
      tag_ff   <= tag_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done;
   assign status.hit  = hit_now;

endmodule

[src/tlvf_out_fifo.sv]
// Result queue: takes up to two results per cycle and hands them out one per transfer.
// Depends on tlvf_pkg.
module tlvf_out_fifo
   import tlvf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_n,
   input  result_type           push_d0,
   input  result_type           push_d1,
   output logic                 room2,
   output logic [OUT_CNT_W-1:0] count,
   output logic                 out_valid,
   input  logic                 out_ready,
   output result_type           out_data
);

   result_type           mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ff, wr_in;
   logic [OUT_PTR_W-1:0] rd_ff, rd_in;
   logic [OUT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 pop;

   assign pop = out_valid && out_ready;

   // Pointer and count update.
   always_comb begin
      wr_in  = wr_ff + OUT_PTR_W'(push_n);
      rd_in  = rd_ff + OUT_PTR_W'(pop);
      cnt_in = cnt_ff + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage writes for one or two results.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= push_d0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ff + OUT_PTR_W'(1)] <= push_d1;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign room2     = (cnt_ff <= OUT_CNT_W'(OUT_DEPTH - 2));
   assign count     = cnt_ff;

endmodule

[src/tlv_stream_parser_tag_filter.sv]
// TLV frame parser with allowed-tag filter, top level. Depends on tlvf_pkg,
// tlvf_tag_scan and tlvf_out_fifo.
// A result is written into the result queue in the accept cycle and goes out on rsp_ from
// its registered storage; one item per cycle is taken while the queue has room for two
// results. The second tag byte starts a walk of up to min(tag_count, depth) entries, one
// per cycle, with no item taken meanwhile. Synchronous reset clears all control state, not the table.
module tlv_stream_parser_tag_filter
   import tlvf_pkg::*;
#(
   parameter int TAG_TABLE_DEPTH = 256,
   parameter int FRAME_SIZE_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: table_index[7:0], tag_word[23:8], frame_size[43:24], data_byte[51:44]
   input  logic [55:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]  req_tuser,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: record_tag[15:0], value_length[31:16], value_offset[47:32],
   // value_byte[55:48], value_end[56], error_code[58:57], parse_position[78:59]
   output logic [79:0] rsp_tdata,
   // tuser: result_kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   // Configuration writes.
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [8:0]  csr_wdata
);

   localparam int FW     = FRAME_SIZE_BITS;
   localparam int TAB_AW = (TAG_TABLE_DEPTH > 1) ? $clog2(TAG_TABLE_DEPTH) : 1;
   localparam int LIM_W  = $clog2(TAG_TABLE_DEPTH + 1);

   // Input fields.
   logic [7:0]  table_index;
   logic [15:0] tag_word;
   logic [19:0] frame_size;
   logic [7:0]  data_byte;

   assign table_index = req_tdata[7:0];
   assign tag_word    = req_tdata[23:8];
   assign frame_size  = req_tdata[43:24];
   assign data_byte   = req_tdata[51:44];

   // Registers.
   logic          byte_order_ff;
   logic [8:0]    tag_count_ff;
   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    first_ff, first_in;
   logic [15:0]   tag_ff, tag_in;
   logic [15:0]   len_ff, len_in;
   logic [15:0]   vcnt_ff, vcnt_in;
   logic [FW-1:0] rem_ff, rem_in;
   logic [FW-1:0] pos_ff, pos_in;

   // Control and datapath signals.
   logic                 req_fire;
   logic                 room2;
   logic [OUT_CNT_W-1:0] fifo_count;
   logic [1:0]           push_n;
   result_type           r0, r1, out_data;
   scan_status_type      scan;
   logic                 scan_start;
   logic                 table_we;
   logic [LIM_W-1:0]     limit;
   logic [15:0]          joined;
   logic [FW-1:0]        rem_dec;
   logic                 val_end;
   logic                 do_bnd;
   logic [FW-1:0]        bnd_rem;
   logic [FW-1:0]        bnd_pos;
   result_type           bnd_res;

   assign req_tready = !reset && !scan.busy && room2;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_ff <= 1'b0;
         tag_count_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BYTE_ORDER: byte_order_ff <= csr_wdata[0];
            CSR_TAG_COUNT:  tag_count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Entries to search, clipped at the table depth.
   assign limit = ({2'b00, tag_count_ff} > 11'(TAG_TABLE_DEPTH)) ?
                  LIM_W'(TAG_TABLE_DEPTH) : LIM_W'(tag_count_ff);

   assign table_we = req_fire && (req_tuser == KIND_LOAD) &&
                     (int'(table_index) < TAG_TABLE_DEPTH);

   // Two-byte field assembly in the configured byte order.
   assign joined  = byte_order_ff ? {first_ff, data_byte} : {data_byte, first_ff};
   assign rem_dec = rem_ff - FW'(1);
   assign val_end = ({1'b0, vcnt_ff} + 17'd1) == {1'b0, len_ff};

   tlvf_tag_scan #(
      .DEPTH  (TAG_TABLE_DEPTH),
      .ADDR_W (TAB_AW),
      .LIM_W  (LIM_W)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (table_we),
      .wr_addr (TAB_AW'(table_index)),
      .wr_data (tag_word),
      .start   (scan_start),
      .tag     (tag_in),
      .limit   (limit),
      .status  (scan)
   );

   // Record boundary: frame done, short tail, or the next tag.
   always_comb begin
      if (bnd_rem == '0) begin
         bnd_res = make_result(RK_DONE, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0, 2'd0,
                               POS_BITS'(bnd_pos));
      end else begin
         bnd_res = make_result(RK_ERROR, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0,
                               ERR_TAG_SHORT, POS_BITS'(bnd_pos));
      end
   end

   // Parser step for an accepted item, or the close of a table walk.
   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      vcnt_in    = vcnt_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      r0         = '0;
      r1         = '0;
      push_n     = 2'd0;
      scan_start = 1'b0;
      do_bnd     = 1'b0;
      bnd_rem    = rem_ff;
      bnd_pos    = pos_ff;

      if (req_fire) begin
         case (req_tuser)
            KIND_START: begin
               rem_in   = FW'(frame_size);
               pos_in   = '0;
               tag_in   = '0;
               len_in   = '0;
               vcnt_in  = '0;
               first_in = '0;
               do_bnd   = 1'b1;
               bnd_rem  = FW'(frame_size);
               bnd_pos  = '0;
            end
            KIND_DATA: begin
               case (phase_ff)
                  PH_TAG0, PH_LEN0: begin
                     first_in = data_byte;
                     rem_in   = rem_dec;
                     phase_in = (phase_ff == PH_TAG0) ? PH_TAG1 : PH_LEN1;
                  end
                  PH_TAG1: begin
                     // The walk decides the next phase.
                     tag_in     = joined;
                     rem_in     = rem_dec;
                     scan_start = 1'b1;
                  end
                  PH_LEN1: begin
                     len_in  = joined;
                     rem_in  = rem_dec;
                     vcnt_in = '0;
                     if (33'(joined) > 33'(rem_dec)) begin
                        phase_in = PH_IDLE;
                        r0 = make_result(RK_ERROR, tag_ff, joined, 16'd0, 8'd0, 1'b0,
                                         ERR_VAL_SHORT, POS_BITS'(pos_ff));
                        push_n = 2'd1;
                     end else if (joined == 16'd0) begin
                        pos_in = pos_ff + FW'(4);
                        r0 = make_result(RK_EMPTY, tag_ff, 16'd0, 16'd0, 8'd0, 1'b0,
                                         2'd0, '0);
                        push_n  = 2'd1;
                        do_bnd  = 1'b1;
                        bnd_rem = rem_dec;
                        bnd_pos = pos_ff + FW'(4);
                     end else begin
                        phase_in = PH_VALUE;
                     end
                  end
                  PH_VALUE: begin
                     r0 = make_result(RK_BYTE, tag_ff, len_ff, vcnt_ff, data_byte, val_end,
                                      2'd0, '0);
                     push_n  = 2'd1;
                     rem_in  = rem_dec;
                     vcnt_in = vcnt_ff + 16'd1;
                     if (val_end) begin
                        pos_in  = pos_ff + FW'(len_ff) + FW'(4);
                        do_bnd  = 1'b1;
                        bnd_rem = rem_dec;
                        bnd_pos = pos_ff + FW'(len_ff) + FW'(4);
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end else if (scan.done) begin
         phase_in = PH_IDLE;
         if (!scan.hit) begin
            r0 = make_result(RK_ERROR, tag_ff, 16'd0, 16'd0, 8'd0, 1'b0, ERR_TAG_BAD,
                             POS_BITS'(pos_ff + rem_ff + FW'(2)));
            push_n = 2'd1;
         end else if (rem_ff < FW'(2)) begin
            r0 = make_result(RK_ERROR, tag_ff, 16'd0, 16'd0, 8'd0, 1'b0, ERR_LEN_SHORT,
                             POS_BITS'(pos_ff));
            push_n = 2'd1;
         end else begin
            phase_in = PH_LEN0;
         end
      end

      // Boundary result goes after any result already queued this cycle.
      if (do_bnd) begin
         if (bnd_rem < FW'(2)) begin
            phase_in = PH_IDLE;
            if (push_n == 2'd0) begin
               r0     = bnd_res;
               push_n = 2'd1;
            end else begin
               r1     = bnd_res;
               push_n = 2'd2;
            end
         end else begin
            phase_in = PH_TAG0;
         end
      end

      // Mark the final result of this step.
      if (push_n == 2'd1) begin
         r0.last = 1'b1;
      end else if (push_n == 2'd2) begin
         r1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         first_ff <= '0;
         tag_ff   <= '0;
         len_ff   <= '0;
         vcnt_ff  <= '0;
         rem_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         vcnt_ff  <= vcnt_in;
         rem_ff   <= rem_in;
         pos_ff   <= pos_in;
      end
   end

   tlvf_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_d0   (r0),
      .push_d1   (r1),
      .room2     (room2),
      .count     (fifo_count),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {1'b0, out_data.pos, out_data.code, out_data.vend, out_data.vbyte,
                       out_data.offset, out_data.len, out_data.tag};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

`ifndef SYNTH
   // The result queue never overflows.
   assert property (@(posedge clock) disable iff (reset)
      (32'(fifo_count) + 32'(push_n)) <= OUT_DEPTH)
      else $error("result queue overflow");

   // No item is taken while the table walk runs.
   assert property (@(posedge clock) disable iff (reset)
      scan.busy |-> !req_fire)
      else $error("item accepted during tag walk");

   // A walk only closes while the second tag byte is pending.
   assert property (@(posedge clock) disable iff (reset)
      scan.done |-> (phase_ff == PH_TAG1))
      else $error("tag walk closed outside tag phase");

   // A walk starts only from an accepted second tag byte and then runs.
   assert property (@(posedge clock) disable iff (reset)
      scan_start |=> scan.busy)
      else $error("tag walk did not start");
`endif

endmodule
